// File: rtl/alte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alte_pkg
// Shared types and constants of the address/line table engine.
// ----------------------------------------------------------------------------
package alte_pkg;

    localparam logic [31:0] TABLE_MAGIC   = 32'h4C53_4447;
    localparam logic [31:0] TABLE_VERSION = 32'd1;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_ADDR = 2'd1;
    localparam logic [1:0] CMD_LINE = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_HEADER   = 3'd1;
    localparam logic [2:0] ST_LENGTH   = 3'd2;
    localparam logic [2:0] ST_ORDER    = 3'd3;
    localparam logic [2:0] ST_TOO_MANY = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIN,
        S_A_SRCH,
        S_A_CMP,
        S_A_LINE,
        S_L_SCAN,
        S_EMIT
    } t_state;

endpackage

// File: rtl/alte_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alte_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module alte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/address_line_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_line_table_engine
// Sorted (start address, line) table, loaded from a word stream and queried
// by address (binary search) or by line (linear scan).
// Load beats: one per cycle; the last beat passes through S_FIN and S_EMIT
// to its status. Address query: each search step is a read of the start RAM,
// then a compare. Line query: one row per cycle through both RAMs, up to the
// row count. One query at a time.
// Reset: synchronous, clears control state; table reads as empty, no sweep.
// ----------------------------------------------------------------------------
module address_line_table_engine #(
    parameter int DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // word
    input  logic        s_axis_tlast,   // last
    input  logic [1:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value
    output logic [4:0]  m_axis_tuser    // found, status[2:0], normalized
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    alte_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_widx, n_widx;
    logic [31:0]   r_hcnt, n_hcnt;
    logic [2:0]    r_err, n_err;
    logic          r_repeat, n_repeat;
    logic [31:0]   r_prev_start, n_prev_start;
    logic [31:0]   r_prev_line, n_prev_line;
    logic [31:0]   r_key, n_key;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic          r_chk, n_chk;
    logic [31:0]   r_res_value, n_res_value;
    logic          r_res_found, n_res_found;
    logic [2:0]    r_res_status, n_res_status;

    logic          r_ovalid;
    logic [31:0]   r_odata;
    logic          r_ofound;
    logic [2:0]    r_ostatus;
    logic          r_onorm;

    logic          acc, out_free, emit_go, hit;
    logic [CW-1:0] mid;
    logic [31:0]   k;
    logic [30:0]   row;
    logic          row_ok;
    logic          st_we, ln_we;
    logic [AW-1:0] st_raddr, ln_raddr;
    logic [31:0]   st_q, ln_q;
    logic [33:0]   expected;
    logic          too_many;
    logic [2:0]    fin_st;

    assign s_axis_tready = (r_state == alte_pkg::S_IDLE);
    assign acc      = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;
    assign emit_go  = (r_state == alte_pkg::S_EMIT) && out_free;
    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign hit      = r_chk && (ln_q == r_key);

    assign k      = r_widx - 32'd3;
    assign row    = k[31:1];
    assign row_ok = (r_widx >= 32'd3) && (row < 31'(DEPTH));
    assign st_we  = acc && (s_axis_tuser == alte_pkg::CMD_LOAD) && row_ok && !k[0];
    assign ln_we  = acc && (s_axis_tuser == alte_pkg::CMD_LOAD) && row_ok && k[0];

    assign st_raddr = (r_state == alte_pkg::S_A_SRCH) ? mid[AW-1:0] : r_lo[AW-1:0];
    assign ln_raddr = (r_state == alte_pkg::S_A_SRCH) ? AW'(r_lo - CW'(1)) : r_lo[AW-1:0];

    alte_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (row[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (st_raddr),
        .o_rdata (st_q)
    );

    alte_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ln_we),
        .i_waddr (row[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (ln_raddr),
        .o_rdata (ln_q)
    );

    // load status, taken in S_FIN after the last beat
    assign expected = 34'd3 + {1'b0, r_hcnt, 1'b0};
    assign too_many = r_hcnt > 32'(DEPTH);

    always_comb begin
        if (r_err == alte_pkg::ST_HEADER) begin
            fin_st = alte_pkg::ST_HEADER;
        end else if (r_widx < 32'd3 || expected != {2'b00, r_widx}) begin
            fin_st = (r_widx >= 32'd3 && too_many) ? alte_pkg::ST_TOO_MANY
                                                   : alte_pkg::ST_LENGTH;
        end else if (too_many) begin
            fin_st = alte_pkg::ST_TOO_MANY;
        end else if (r_err == alte_pkg::ST_ORDER) begin
            fin_st = alte_pkg::ST_ORDER;
        end else begin
            fin_st = alte_pkg::ST_OK;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            alte_pkg::S_IDLE: begin
                if (acc) begin
                    case (s_axis_tuser)
                        alte_pkg::CMD_LOAD: if (s_axis_tlast) n_state = alte_pkg::S_FIN;
                        alte_pkg::CMD_ADDR: n_state = alte_pkg::S_A_SRCH;
                        alte_pkg::CMD_LINE: n_state = alte_pkg::S_L_SCAN;
                        default:            n_state = alte_pkg::S_IDLE;
                    endcase
                end
            end
            alte_pkg::S_FIN: n_state = alte_pkg::S_EMIT;
            alte_pkg::S_A_SRCH: begin
                if (r_lo < r_hi) begin
                    n_state = alte_pkg::S_A_CMP;
                end else if (r_lo == '0) begin
                    n_state = alte_pkg::S_EMIT;
                end else begin
                    n_state = alte_pkg::S_A_LINE;
                end
            end
            alte_pkg::S_A_CMP:  n_state = alte_pkg::S_A_SRCH;
            alte_pkg::S_A_LINE: n_state = alte_pkg::S_EMIT;
            alte_pkg::S_L_SCAN: begin
                if (hit || (r_lo == r_count && !r_chk)) begin
                    n_state = alte_pkg::S_EMIT;
                end
            end
            alte_pkg::S_EMIT: if (out_free) n_state = alte_pkg::S_IDLE;
            default: n_state = alte_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_widx       = r_widx;
        n_hcnt       = r_hcnt;
        n_err        = r_err;
        n_repeat     = r_repeat;
        n_prev_start = r_prev_start;
        n_prev_line  = r_prev_line;
        n_key        = r_key;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_chk        = r_chk;
        n_res_value  = r_res_value;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        unique case (r_state)
            alte_pkg::S_IDLE: begin
                if (acc && s_axis_tuser == alte_pkg::CMD_LOAD) begin
                    if (r_widx == 32'd0) begin
                        n_count  = '0;
                        n_hcnt   = '0;
                        n_repeat = 1'b0;
                        n_err    = (s_axis_tdata != alte_pkg::TABLE_MAGIC)
                                   ? alte_pkg::ST_HEADER : alte_pkg::ST_OK;
                    end else if (r_widx == 32'd1) begin
                        if (s_axis_tdata != alte_pkg::TABLE_VERSION
                            && r_err == alte_pkg::ST_OK) begin
                            n_err = alte_pkg::ST_HEADER;
                        end
                    end else if (r_widx == 32'd2) begin
                        n_hcnt = s_axis_tdata;
                    end else if (row_ok) begin
                        if (!k[0]) begin
                            n_prev_start = s_axis_tdata;
                            if (row != '0 && s_axis_tdata <= r_prev_start
                                && r_err == alte_pkg::ST_OK) begin
                                n_err = alte_pkg::ST_ORDER;
                            end
                        end else begin
                            n_prev_line = s_axis_tdata;
                            if (row != '0 && s_axis_tdata == r_prev_line) begin
                                n_repeat = 1'b1;
                            end
                        end
                    end
                    if (r_widx != 32'hFFFF_FFFF) begin
                        n_widx = r_widx + 32'd1;
                    end
                end else if (acc) begin
                    n_key = s_axis_tdata;
                    n_lo  = '0;
                    n_hi  = r_count;
                    n_chk = 1'b0;
                end
            end
            alte_pkg::S_FIN: begin
                n_res_value  = '0;
                n_res_found  = 1'b0;
                n_res_status = fin_st;
                n_err        = fin_st;
                n_widx       = '0;
                if (fin_st == alte_pkg::ST_OK) begin
                    n_count = r_hcnt[CW-1:0];
                end else begin
                    n_count  = '0;
                    n_repeat = 1'b0;
                end
            end
            alte_pkg::S_A_SRCH: begin
                if (!(r_lo < r_hi) && r_lo == '0) begin
                    n_res_value  = '0;
                    n_res_found  = 1'b0;
                    n_res_status = alte_pkg::ST_OK;
                end
            end
            alte_pkg::S_A_CMP: begin
                if (r_key < st_q) begin
                    n_hi = mid;
                end else begin
                    n_lo = mid + CW'(1);
                end
            end
            alte_pkg::S_A_LINE: begin
                n_res_value  = ln_q;
                n_res_found  = 1'b1;
                n_res_status = alte_pkg::ST_OK;
            end
            alte_pkg::S_L_SCAN: begin
                if (hit) begin
                    n_res_value  = st_q;
                    n_res_found  = 1'b1;
                    n_res_status = alte_pkg::ST_OK;
                end else if (r_lo == r_count && !r_chk) begin
                    n_res_value  = '0;
                    n_res_found  = 1'b0;
                    n_res_status = alte_pkg::ST_OK;
                end else if (r_lo < r_count) begin
                    n_lo  = r_lo + CW'(1);
                    n_chk = 1'b1;
                end else begin
                    n_chk = 1'b0;
                end
            end
            alte_pkg::S_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= alte_pkg::S_IDLE;
            r_count  <= '0;
            r_widx   <= '0;
            r_hcnt   <= '0;
            r_err    <= alte_pkg::ST_OK;
            r_repeat <= 1'b0;
            r_chk    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_widx   <= n_widx;
            r_hcnt   <= n_hcnt;
            r_err    <= n_err;
            r_repeat <= n_repeat;
            r_chk    <= n_chk;
            if (emit_go) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev_start <= n_prev_start;
        r_prev_line  <= n_prev_line;
        r_key        <= n_key;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_res_value  <= n_res_value;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
        if (emit_go) begin
            r_odata   <= r_res_value;
            r_ofound  <= r_res_found;
            r_ostatus <= r_res_status;
            r_onorm   <= !r_repeat;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = {r_onorm, r_ostatus, r_ofound};

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("row count above capacity");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_ofound) |-> (r_odata == 32'd0))
        else $error("miss with non-zero value");

    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ofound) |-> (r_ostatus == alte_pkg::ST_OK))
        else $error("hit with load status");

    a_fail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == alte_pkg::S_FIN)
        |=> (r_res_status == alte_pkg::ST_OK || (r_count == '0 && !r_repeat)))
        else $error("failed load left rows");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == alte_pkg::S_L_SCAN) |-> (r_lo <= r_count))
        else $error("scan index past row count");

endmodule
